FILE: rtl/core/wdws_pkg.sv
// ============================================================================
// wdws_pkg: shared types and constants of the weighted distance block
// Fixed-point formats, register indexes, specificity modes and the root
// sequencer states.
// ============================================================================
package wdws_pkg;

   // Fraction bits of the Q4.12 inputs and the value of 1.0 in that format.
   localparam int FRAC_BITS = 12;
   localparam int ONE_Q     = 1 << FRAC_BITS;

   // Width of the Q12.12 distance result.
   localparam int DIST_BITS = 24;

   // Configuration port geometry.
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPEC_MODE   = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MULTI_CLASS = CSR_INDEX_BITS'(1);

   // Entries of the queue between the accumulator and the root unit.
   localparam int QUEUE_DEPTH = 2;

   // Specificity modes; the reserved code behaves as no specificities.
   typedef enum logic [1:0] {
      SPEC_NONE     = 2'd0,
      SPEC_GLOBAL   = 2'd1,
      SPEC_CLASS    = 2'd2,
      SPEC_RESERVED = 2'd3
   } spec_mode_type;

   // Configuration as seen by the front end.
   typedef struct packed {
      logic [1:0] spec_mode;
      logic       multi_class;
   } cfg_type;

   // Square root sequencer states.
   typedef enum logic [1:0] {
      ROOT_IDLE,
      ROOT_RUN,
      ROOT_DONE
   } root_state_type;

endpackage

FILE: rtl/core/wdws_if.sv
// ============================================================================
// wdws_if: streaming channels of the weighted distance block
// One request channel carrying a dimension item and one response channel
// carrying a distance result, both with valid/ready flow control.
// ============================================================================
interface wdws_req_if #(
   parameter int VALUE_BITS = 16
);
   logic                         valid;
   logic                         ready;
   logic signed [VALUE_BITS-1:0] coord_first;
   logic signed [VALUE_BITS-1:0] coord_second;
   logic        [VALUE_BITS-1:0] dim_weight;
   logic                         last_dim;
   logic signed [VALUE_BITS-1:0] spec_first;
   logic signed [VALUE_BITS-1:0] spec_second;
   logic        [VALUE_BITS-1:0] spec_weight;

   modport source (
      output valid, coord_first, coord_second, dim_weight, last_dim,
             spec_first, spec_second, spec_weight,
      input  ready
   );

   modport sink (
      input  valid, coord_first, coord_second, dim_weight, last_dim,
             spec_first, spec_second, spec_weight,
      output ready
   );
endinterface

interface wdws_rsp_if
   import wdws_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [DIST_BITS-1:0] distance;
   logic                 saturated;

   modport source (
      output valid, distance, saturated,
      input  ready
   );

   modport sink (
      input  valid, distance, saturated,
      output ready
   );
endinterface

FILE: rtl/core/wdws_front.sv
// ============================================================================
// wdws_front: term pipeline and saturating accumulator
// Accepts one dimension per cycle while the queue is not full, forms the
// weighted squared difference and the specificity term, accumulates per
// pair and hands each finished, clamped sum to the queue.
// ============================================================================
module wdws_front
   import wdws_pkg::*;
#(
   parameter int VALUE_BITS = 16,
   parameter int ACC_BITS   = 48
) (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   wdws_req_if.sink            req_if,
   input  logic                queue_full,
   output logic                push_valid,
   output logic [ACC_BITS-2:0] push_value,
   output logic                push_flag
);

   // Weights must be able to hold 1.0 in single-class mode.
   localparam int WB  = (VALUE_BITS > FRAC_BITS) ? VALUE_BITS : FRAC_BITS + 1;
   localparam int SPW = VALUE_BITS + 1 + WB;
   localparam int PW  = WB + 2 * VALUE_BITS;
   localparam int SW  = PW - FRAC_BITS;
   localparam int XW  = (SW > ACC_BITS - 1) ? SW : ACC_BITS - 1;
   localparam int YW  = (SPW > ACC_BITS) ? SPW : ACC_BITS;

   localparam logic [XW-1:0]       WTERM_MAX = XW'({(ACC_BITS - 1){1'b1}});
   localparam logic [YW-1:0]       SPEC_CAP  = YW'(1) << (ACC_BITS - 1);
   localparam logic [ACC_BITS-1:0] ACC_MAX   = {1'b0, {(ACC_BITS - 1){1'b1}}};
   localparam logic [ACC_BITS-1:0] ACC_MIN   = {1'b1, {(ACC_BITS - 1){1'b0}}};

   logic advance;
   logic accept;

   // Input classification.
   logic                  spec_en;
   logic                  use_spec_weight;
   logic [VALUE_BITS:0]   diff;
   logic [VALUE_BITS:0]   diff_mag;
   logic [VALUE_BITS:0]   spec_sum;
   logic [VALUE_BITS:0]   spec_mag;

   // Stage 1 registers.
   logic                  s1_valid_ff;
   logic                  s1_last_ff;
   logic [VALUE_BITS-1:0] s1_mag_ff;
   logic [WB-1:0]         s1_weight_ff;
   logic [VALUE_BITS:0]   s1_smag_ff;
   logic                  s1_sneg_ff;
   logic [WB-1:0]         s1_sweight_ff;

   // Stage 2 registers.
   logic                    s2_valid_ff;
   logic                    s2_last_ff;
   logic [2*VALUE_BITS-1:0] s2_sq_ff;
   logic [WB-1:0]           s2_weight_ff;
   logic [SPW-1:0]          s2_sprod_ff;
   logic                    s2_sneg_ff;

   // Stage 3 registers.
   logic                     s3_valid_ff;
   logic                     s3_last_ff;
   logic [WB+VALUE_BITS-1:0] s3_plo_ff;
   logic [WB+VALUE_BITS-1:0] s3_phi_ff;
   logic [SPW-1:0]           s3_sprod_ff;
   logic                     s3_sneg_ff;

   // Stage 4 logic and registers.
   logic [PW-1:0]              prod;
   logic [XW-1:0]              wterm_wide;
   logic                       wsat;
   logic [ACC_BITS-2:0]        wterm;
   logic [YW-1:0]              spec_wide;
   logic [YW-1:0]              spec_clamped;
   logic                       ssat;
   logic signed [ACC_BITS-1:0] sterm;

   logic                       s4_valid_ff;
   logic                       s4_last_ff;
   logic [ACC_BITS-2:0]        s4_wterm_ff;
   logic                       s4_wsat_ff;
   logic signed [ACC_BITS-1:0] s4_sterm_ff;
   logic                       s4_ssat_ff;

   // Accumulator.
   logic signed [ACC_BITS-1:0] acc_ff;
   logic                       overflow_ff;
   logic [ACC_BITS:0]          acc_sum;
   logic                       acc_ovf;
   logic [ACC_BITS-1:0]        acc_sat;
   logic                       overflow_next;

   // Final stage registers and logic.
   logic                       s5_valid_ff;
   logic [ACC_BITS-1:0]        s5_sum_ff;
   logic [ACC_BITS-1:0]        s5_sterm_ff;
   logic                       s5_flag_ff;
   logic [ACC_BITS:0]          total;
   logic                       total_ovf;
   logic [ACC_BITS-1:0]        total_sat;
   logic                       total_neg;

   // The whole pipeline moves together and stalls only on a full queue.
   assign advance      = !(s5_valid_ff && queue_full);
   assign req_if.ready = advance;
   assign accept       = req_if.valid && advance;

   // Decode the specificity mode for the incoming item.
   always_comb begin
      unique case (cfg.spec_mode)
         SPEC_GLOBAL: begin
            spec_en         = 1'b1;
            use_spec_weight = cfg.multi_class;
         end
         SPEC_CLASS: begin
            spec_en         = 1'b1;
            use_spec_weight = 1'b0;
         end
         default: begin
            spec_en         = 1'b0;
            use_spec_weight = 1'b0;
         end
      endcase
   end

   // Exact coordinate difference, specificity sum and their magnitudes.
   always_comb begin
      diff     = {req_if.coord_second[VALUE_BITS-1], req_if.coord_second}
               - {req_if.coord_first[VALUE_BITS-1], req_if.coord_first};
      diff_mag = diff[VALUE_BITS] ? ('0 - diff) : diff;
      spec_sum = {req_if.spec_first[VALUE_BITS-1], req_if.spec_first}
               + {req_if.spec_second[VALUE_BITS-1], req_if.spec_second};
      spec_mag = spec_sum[VALUE_BITS] ? ('0 - spec_sum) : spec_sum;
   end

   // Stage 1: register the classified item.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= accept;
      end
      if (advance) begin
         s1_last_ff    <= req_if.last_dim;
         s1_mag_ff     <= diff_mag[VALUE_BITS-1:0];
         s1_weight_ff  <= cfg.multi_class ? WB'(req_if.dim_weight) : WB'(ONE_Q);
         s1_smag_ff    <= (spec_en && req_if.last_dim) ? spec_mag : '0;
         s1_sneg_ff    <= spec_sum[VALUE_BITS];
         s1_sweight_ff <= use_spec_weight ? WB'(req_if.spec_weight) : WB'(ONE_Q);
      end
   end

   // Stage 2: square of the difference and the specificity product.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (advance) begin
         s2_last_ff   <= s1_last_ff;
         s2_sq_ff     <= s1_mag_ff * s1_mag_ff;
         s2_weight_ff <= s1_weight_ff;
         s2_sprod_ff  <= s1_smag_ff * s1_sweight_ff;
         s2_sneg_ff   <= s1_sneg_ff;
      end
   end

   // Stage 3: weight times the square, as two partial products.
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (advance) begin
         s3_last_ff  <= s2_last_ff;
         s3_plo_ff   <= s2_weight_ff * s2_sq_ff[VALUE_BITS-1:0];
         s3_phi_ff   <= s2_weight_ff * s2_sq_ff[2*VALUE_BITS-1:VALUE_BITS];
         s3_sprod_ff <= s2_sprod_ff;
         s3_sneg_ff  <= s2_sneg_ff;
      end
   end

   // Combine the partial products, drop the weight fraction and clamp both
   // terms to the accumulator range.
   always_comb begin
      prod       = (PW'(s3_phi_ff) << VALUE_BITS) + PW'(s3_plo_ff);
      wterm_wide = XW'(prod[PW-1:FRAC_BITS]);
      wsat       = wterm_wide > WTERM_MAX;
      wterm      = wsat ? '1 : wterm_wide[ACC_BITS-2:0];

      spec_wide = YW'(s3_sprod_ff);
      if (s3_sneg_ff) begin
         ssat         = spec_wide > SPEC_CAP;
         spec_clamped = ssat ? SPEC_CAP : spec_wide;
         sterm        = '0 - spec_clamped[ACC_BITS-1:0];
      end else begin
         ssat         = spec_wide >= SPEC_CAP;
         spec_clamped = spec_wide;
         sterm        = ssat ? ACC_MAX : spec_clamped[ACC_BITS-1:0];
      end
   end

   // Stage 4: clamped terms.
   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= s3_valid_ff;
      end
      if (advance) begin
         s4_last_ff  <= s3_last_ff;
         s4_wterm_ff <= wterm;
         s4_wsat_ff  <= wsat;
         s4_sterm_ff <= sterm;
         s4_ssat_ff  <= ssat;
      end
   end

   // Saturating add of the dimension term.
   always_comb begin
      acc_sum       = {acc_ff[ACC_BITS-1], acc_ff} + {2'b00, s4_wterm_ff};
      acc_ovf       = acc_sum[ACC_BITS] != acc_sum[ACC_BITS-1];
      acc_sat       = acc_ovf ? ACC_MAX : acc_sum[ACC_BITS-1:0];
      overflow_next = overflow_ff || s4_wsat_ff || acc_ovf;
   end

   // Accumulator; the last dimension hands the pair on and clears it.
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff      <= '0;
         overflow_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else if (advance) begin
         s5_valid_ff <= s4_valid_ff && s4_last_ff;
         if (s4_valid_ff) begin
            if (s4_last_ff) begin
               acc_ff      <= '0;
               overflow_ff <= 1'b0;
            end else begin
               acc_ff      <= acc_sat;
               overflow_ff <= overflow_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s5_sum_ff   <= acc_sat;
         s5_sterm_ff <= s4_sterm_ff;
         s5_flag_ff  <= overflow_next || s4_ssat_ff;
      end
   end

   // Final stage: add the specificity term and clamp a negative sum.
   always_comb begin
      total     = {s5_sum_ff[ACC_BITS-1], s5_sum_ff}
                + {s5_sterm_ff[ACC_BITS-1], s5_sterm_ff};
      total_ovf = total[ACC_BITS] != total[ACC_BITS-1];
      if (total_ovf) begin
         total_sat = total[ACC_BITS] ? ACC_MIN : ACC_MAX;
      end else begin
         total_sat = total[ACC_BITS-1:0];
      end
      total_neg = total_sat[ACC_BITS-1];
   end

   assign push_valid = s5_valid_ff && !queue_full;
   assign push_value = total_neg ? '0 : total_sat[ACC_BITS-2:0];
   assign push_flag  = s5_flag_ff || total_ovf || total_neg;

endmodule

FILE: rtl/core/wdws_queue.sv
// ============================================================================
// wdws_queue: short first-in first-out queue of finished sums
// Decouples the accumulator from the square root unit.
// ============================================================================
module wdws_queue
   import wdws_pkg::*;
#(
   parameter int WIDTH = 48
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data
);

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   logic [WIDTH-1:0]  entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff;
   logic [PTR_BITS-1:0] rd_ptr_ff;
   logic [PTR_BITS:0]   count_ff;

   assign full       = count_ff == (PTR_BITS + 1)'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_data  = entry_ff[rd_ptr_ff];

   // Storage; the producer never pushes into a full queue.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Pointers wrap at the power-of-two depth.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

FILE: rtl/core/wdws_root.sv
// ============================================================================
// wdws_root: bit-serial integer square root and result register
// Takes one sum from the queue, resolves one root bit per cycle, caps the
// root to the distance width and holds the result for the receiver.
// ============================================================================
module wdws_root
   import wdws_pkg::*;
#(
   parameter int ACC_BITS = 48
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  logic [ACC_BITS-2:0] head_value,
   input  logic                head_flag,
   output logic                pop,
   wdws_rsp_if.source          rsp_if
);

   localparam int RB       = ACC_BITS / 2;
   localparam int CNT_BITS = $clog2(RB + 1);
   localparam int CW       = (RB > DIST_BITS) ? RB : DIST_BITS;

   localparam logic [CW-1:0] DIST_MAX = CW'({DIST_BITS{1'b1}});

   root_state_type state_ff;
   root_state_type state_in;

   logic                  load_out;
   logic [2*RB-1:0]       rad_ff;
   logic [RB+1:0]         rem_ff;
   logic [RB-1:0]         root_ff;
   logic [CNT_BITS-1:0]   cnt_ff;
   logic                  flag_ff;

   logic [RB+3:0]         rem_cat;
   logic [RB+3:0]         trial;
   logic [RB+3:0]         rem_diff;
   logic                  fits;
   logic [CW-1:0]         root_wide;
   logic                  root_cap;

   logic                  out_valid_ff;
   logic [DIST_BITS-1:0]  distance_ff;
   logic                  saturated_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ROOT_IDLE: begin
            if (head_valid) begin
               state_in = ROOT_RUN;
            end
         end
         ROOT_RUN: begin
            if (cnt_ff == CNT_BITS'(1)) begin
               state_in = ROOT_DONE;
            end
         end
         ROOT_DONE: begin
            if (!out_valid_ff || rsp_if.ready) begin
               state_in = ROOT_IDLE;
            end
         end
         default: state_in = ROOT_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      pop      = 1'b0;
      load_out = 1'b0;
      unique case (state_ff)
         ROOT_IDLE: pop      = head_valid;
         ROOT_DONE: load_out = !out_valid_ff || rsp_if.ready;
         default: begin
            pop      = 1'b0;
            load_out = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ROOT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // One restoring root step: bring down two radicand bits and try 4r+1.
   always_comb begin
      rem_cat  = {rem_ff, rad_ff[2*RB-1 -: 2]};
      trial    = (RB + 4)'({root_ff, 2'b01});
      fits     = rem_cat >= trial;
      rem_diff = rem_cat - trial;
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rad_ff  <= (2 * RB)'(head_value);
         rem_ff  <= '0;
         root_ff <= '0;
         cnt_ff  <= CNT_BITS'(RB);
         flag_ff <= head_flag;
      end else if (state_ff == ROOT_RUN) begin
         rad_ff  <= rad_ff << 2;
         rem_ff  <= fits ? rem_diff[RB+1:0] : rem_cat[RB+1:0];
         root_ff <= {root_ff[RB-2:0], fits};
         cnt_ff  <= cnt_ff - 1'b1;
      end
   end

   // Cap a root that does not fit the distance field.
   assign root_wide = CW'(root_ff);
   assign root_cap  = root_wide > DIST_MAX;

   // Result register; a new result loads as the previous one transfers.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         distance_ff  <= root_cap ? '1 : root_wide[DIST_BITS-1:0];
         saturated_ff <= flag_ff || root_cap;
      end
   end

   assign rsp_if.valid     = out_valid_ff;
   assign rsp_if.distance  = distance_ff;
   assign rsp_if.saturated = saturated_ff;

endmodule

FILE: rtl/core/weighted_distance_with_specificities.sv
// ============================================================================
// weighted_distance_with_specificities: weighted distance for one class
// Top level: configuration registers, term pipeline, queue and root unit.
// ============================================================================
// The request channel carries one dimension of a stimulus pair per transfer;
// last_dim closes the pair. The front end takes one dimension every cycle
// while the queue is not full, through a five-stage pipeline (difference,
// square, weighting, clamping, accumulation) and adds the specificity term
// on the last dimension. Each finished sum enters a two-entry queue. The
// root unit takes one sum at a time and resolves one root bit per cycle; it
// takes the next sum only after its result is loaded into the output
// register, so short pairs can fill the queue and hold the request channel.
// The response channel holds its result in an output register; while the
// receiver stalls, the root unit finishes the next pair and waits, the queue
// fills, and then the request channel drops ready.
// Reset clears the configuration, the accumulator and all valid state.
// Configuration is written through csr_we/csr_index/csr_wdata; the user must
// write it only while idle, as the block itself does not enforce this.
// ============================================================================
module weighted_distance_with_specificities
   import wdws_pkg::*;
#(
   parameter int VALUE_BITS = 16,
   parameter int ACC_BITS   = 48
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   wdws_req_if.sink                  req_if,
   wdws_rsp_if.source                rsp_if
);

   logic [1:0]          spec_mode_ff;
   logic                multi_class_ff;
   cfg_type             cfg;

   logic                push_valid;
   logic [ACC_BITS-2:0] push_value;
   logic                push_flag;
   logic                queue_full;
   logic                queue_pop;
   logic                head_valid;
   logic [ACC_BITS-1:0] head_data;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         spec_mode_ff   <= SPEC_NONE;
         multi_class_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SPEC_MODE:   spec_mode_ff   <= csr_wdata;
            CSR_MULTI_CLASS: multi_class_ff <= csr_wdata[0];
            default:         spec_mode_ff   <= spec_mode_ff;
         endcase
      end
   end

   assign cfg.spec_mode   = spec_mode_ff;
   assign cfg.multi_class = multi_class_ff;

   // Term pipeline and accumulator.
   wdws_front #(
      .VALUE_BITS (VALUE_BITS),
      .ACC_BITS   (ACC_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_if     (req_if),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_value (push_value),
      .push_flag  (push_flag)
   );

   // Queue of finished sums.
   wdws_queue #(
      .WIDTH (ACC_BITS)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_data  ({push_value, push_flag}),
      .full       (queue_full),
      .pop        (queue_pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   // Square root and result register.
   wdws_root #(
      .ACC_BITS (ACC_BITS)
   ) u_root (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_value (head_data[ACC_BITS-1:1]),
      .head_flag  (head_data[0]),
      .pop        (queue_pop),
      .rsp_if     (rsp_if)
   );

endmodule
